// File: rtl/core/spc_pkg.sv
// Package for the speed PID controller: register indexes, stage count and
// fixed arithmetic constants. No dependencies.

package spc_pkg;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_GAIN_P       = 2'd0,
      CSR_GAIN_I       = 2'd1,
      CSR_GAIN_D       = 2'd2,
      CSR_OUTPUT_LIMIT = 2'd3
   } csr_index_type;

   // Pipeline depth from the input register to the result register.
   localparam int NUM_STAGES = 7;

   // Error clamps for the proportional and integral paths (13-bit signed).
   localparam logic signed [12:0] P_ERR_CLAMP = 13'sd700;
   localparam logic signed [12:0] I_ERR_CLAMP = 13'sd600;

   // Accumulator saturation bound (17-bit signed).
   localparam logic signed [16:0] ACC_CLAMP = 17'sd50000;

   // Reciprocal of 100 for magnitudes below 2**22: floor(m / 100) equals
   // (m * DIV100_MULT) >> DIV100_SHIFT.
   localparam logic [22:0] DIV100_MULT  = 23'd5368710;
   localparam int          DIV100_SHIFT = 29;

   // Reset value of the drive bound.
   localparam logic [14:0] OUTPUT_LIMIT_RESET = 15'd1000;

endpackage

// File: rtl/core/speed_pid_controller.sv
// Speed PID controller top level: a seven-stage pipeline that turns encoder
// counts and a target speed into a saturated drive value.
// Depends on spc_pkg.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------------
//  req      | in        | req_valid / req_ready   | count_left, count_right, target_speed
//  rsp      | out       | rsp_valid / rsp_ready   | drive, measured_speed
//  csr      | in        | csr_write_enable        | csr_index, csr_data
//
// One beat is accepted per cycle unless every stage is full and rsp_ready is low;
// the edge that accepts a beat loads it into the input register, and from there it
// passes stage by stage to the result register. The depth is set by the chain of
// stages: error forming, gain products, accumulator, total, divide and saturate.
// Reset clears all valid bits, the previous error, the accumulator and the
// gains, and sets the drive bound to its default; no clearing pass follows it.
// Each stage holds its beat only while the stage after it is full and stalled,
// so empty stages keep taking beats while a finished result waits on rsp_ready.

module speed_pid_controller
   import spc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [11:0] req_count_left,
   input  logic signed [11:0] req_count_right,
   input  logic signed [11:0] req_target_speed,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_drive,
   output logic signed [11:0] rsp_measured_speed,

   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_data
);

   // ---------------------------------------------------------------------
   // Configuration registers. The user must change them only while the pipeline
   // is idle; the block does not enforce it. The stages read them directly.
   // ---------------------------------------------------------------------
   logic [7:0]  gain_p_ff, gain_i_ff, gain_d_ff;
   logic [14:0] output_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff       <= '0;
         gain_i_ff       <= '0;
         gain_d_ff       <= '0;
         output_limit_ff <= OUTPUT_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_P:       gain_p_ff       <= csr_data[7:0];
            CSR_GAIN_I:       gain_i_ff       <= csr_data[7:0];
            CSR_GAIN_D:       gain_d_ff       <= csr_data[7:0];
            CSR_OUTPUT_LIMIT: output_limit_ff <= csr_data;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control. A stage may load when it is empty or when the
   // stage after it loads in the same cycle; the result register may load
   // when it is empty or its beat is being taken.
   // ---------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = load[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // ---------------------------------------------------------------------
   // Stage 0: input register.
   // ---------------------------------------------------------------------
   logic signed [11:0] left_ff, right_ff, target_ff;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         left_ff   <= req_count_left;
         right_ff  <= req_count_right;
         target_ff <= req_target_speed;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: measured speed, error, clamped errors and error change.
   // The halving rounds toward zero, so negative sums get one added
   // before the arithmetic shift.
   // ---------------------------------------------------------------------
   logic signed [12:0] count_sum;
   logic signed [12:0] speed_wide;
   logic signed [12:0] error_in;
   logic signed [12:0] err_p_wide, err_i_wide;
   logic signed [13:0] error_change;

   logic signed [12:0] prev_error_ff;
   logic signed [11:0] speed1_ff;
   logic signed [10:0] err_p_ff, err_i_ff;
   logic signed [13:0] error_change_ff;

   always_comb begin
      count_sum  = {left_ff[11], left_ff} + {right_ff[11], right_ff};
      speed_wide = (count_sum + $signed({12'd0, count_sum[12]})) >>> 1;
      error_in   = {target_ff[11], target_ff} - speed_wide;

      if (error_in > P_ERR_CLAMP) begin
         err_p_wide = P_ERR_CLAMP;
      end else if (error_in < -P_ERR_CLAMP) begin
         err_p_wide = -P_ERR_CLAMP;
      end else begin
         err_p_wide = error_in;
      end

      if (error_in > I_ERR_CLAMP) begin
         err_i_wide = I_ERR_CLAMP;
      end else if (error_in < -I_ERR_CLAMP) begin
         err_i_wide = -I_ERR_CLAMP;
      end else begin
         err_i_wide = error_in;
      end

      error_change = {error_in[12], error_in} - {prev_error_ff[12], prev_error_ff};
   end

   // The previous error advances only when a real beat enters stage 1.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
      end else if (load[1] && valid_ff[0]) begin
         prev_error_ff <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         speed1_ff       <= speed_wide[11:0];
         err_p_ff        <= err_p_wide[10:0];
         err_i_ff        <= err_i_wide[10:0];
         error_change_ff <= error_change;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: the three gain products.
   // ---------------------------------------------------------------------
   logic signed [19:0] prop2_ff;
   logic signed [22:0] deriv2_ff;
   logic signed [19:0] int_step2_ff;
   logic signed [11:0] speed2_ff;

   always_ff @(posedge clock) begin
      if (load[2]) begin
         prop2_ff     <= 20'(err_p_ff) * 20'($signed({1'b0, gain_p_ff}));
         deriv2_ff    <= 23'(error_change_ff) * 23'($signed({1'b0, gain_d_ff}));
         int_step2_ff <= 20'(err_i_ff) * 20'($signed({1'b0, gain_i_ff}));
         speed2_ff    <= speed1_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: accumulator. The unclamped sum goes on to the drive path; the
   // stored sum is saturated afterwards.
   // ---------------------------------------------------------------------
   logic signed [19:0] acc_sum;
   logic signed [16:0] integral_in;
   logic signed [16:0] integral_ff;

   logic signed [19:0] prop3_ff;
   logic signed [22:0] deriv3_ff;
   logic signed [19:0] acc3_ff;
   logic signed [11:0] speed3_ff;

   always_comb begin
      acc_sum = {{3{integral_ff[16]}}, integral_ff} + int_step2_ff;
      if (acc_sum > 20'(ACC_CLAMP)) begin
         integral_in = ACC_CLAMP;
      end else if (acc_sum < -20'(ACC_CLAMP)) begin
         integral_in = -ACC_CLAMP;
      end else begin
         integral_in = acc_sum[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
      end else if (load[3] && valid_ff[2]) begin
         integral_ff <= integral_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         prop3_ff  <= prop2_ff;
         deriv3_ff <= deriv2_ff;
         acc3_ff   <= acc_sum;
         speed3_ff <= speed2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: total before scaling. The division by eight rounds toward
   // zero, so negative sums are biased by seven before the shift.
   // ---------------------------------------------------------------------
   logic signed [19:0] acc_eighth;
   logic signed [23:0] total_in;
   logic signed [23:0] total4_ff;
   logic signed [11:0] speed4_ff;

   always_comb begin
      acc_eighth = (acc3_ff + $signed({17'd0, {3{acc3_ff[19]}}})) >>> 3;
      total_in   = {{4{prop3_ff[19]}}, prop3_ff} + {deriv3_ff[22], deriv3_ff}
                 + {{4{acc_eighth[19]}}, acc_eighth};
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         total4_ff <= total_in;
         speed4_ff <= speed3_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: divide the magnitude by 100 with a reciprocal multiply.
   // ---------------------------------------------------------------------
   logic [23:0] total_abs;
   logic [44:0] quot_product;
   logic [14:0] quot5_ff;
   logic        neg5_ff;
   logic signed [11:0] speed5_ff;

   always_comb begin
      total_abs    = total4_ff[23] ? 24'(-total4_ff) : 24'(total4_ff);
      quot_product = {23'd0, total_abs[21:0]} * {22'd0, DIV100_MULT};
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         quot5_ff  <= quot_product[DIV100_SHIFT+14:DIV100_SHIFT];
         neg5_ff   <= total4_ff[23];
         speed5_ff <= speed4_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6: saturate to the drive bound, restore the sign, result register.
   // ---------------------------------------------------------------------
   logic [14:0]        drive_mag;
   logic signed [15:0] drive_in;
   logic signed [15:0] drive_ff;
   logic signed [11:0] speed6_ff;

   always_comb begin
      drive_mag = (quot5_ff > output_limit_ff) ? output_limit_ff : quot5_ff;
      drive_in  = neg5_ff ? -$signed({1'b0, drive_mag}) : $signed({1'b0, drive_mag});
   end

   always_ff @(posedge clock) begin
      if (load[6]) begin
         drive_ff  <= drive_in;
         speed6_ff <= speed5_ff;
      end
   end

   assign rsp_drive          = drive_ff;
   assign rsp_measured_speed = speed6_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // The stored accumulator never leaves its saturation band.
   a_integral_bound: assert property (@(posedge clock) disable iff (reset)
      (integral_ff <= ACC_CLAMP) && (integral_ff >= -ACC_CLAMP))
      else $error("accumulator outside its saturation band");

   // A delivered drive respects the configured bound.
   a_drive_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_drive <= $signed({1'b0, output_limit_ff}))
                  && (rsp_drive >= -$signed({1'b0, output_limit_ff}))))
      else $error("drive beyond output limit");

   // With the consumer ready, the pipeline never refuses a beat.
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output is free");

   // An accepted beat occupies the input stage in the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> valid_ff[0])
      else $error("accepted beat lost at input stage");

endmodule
